>>> src/cds_pkg.sv
`default_nettype none

package cds_pkg;

	localparam int unsigned KIND_W  = 3;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned EPOCH_W = 22;
	localparam int unsigned WD_W    = 3;
	localparam int unsigned ACC_W   = 22;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned PC_W    = 4;

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [EPOCH_W-1:0] epoch_t;
	typedef logic [WD_W-1:0]    wd_t;
	typedef logic [ACC_W-1:0]   acc_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [PC_W-1:0]    pc_t;

	localparam year_t  YEAR_MIN   = 14'd1;
	localparam year_t  YEAR_MAX   = 14'd9999;
	localparam year_t  EPOCH_YEAR = 14'd1970;
	localparam month_t MONTH_JAN  = 4'd1;
	localparam month_t MONTH_FEB  = 4'd2;
	localparam month_t MONTH_DEC  = 4'd12;
	localparam day_t   DAY_FIRST  = 5'd1;
	localparam day_t   DAY_LAST   = 5'd31;
	localparam epoch_t EPOCH_MAX  = 22'd2932896;
	// Days from 0001-01-01 to 1970-01-01.
	localparam acc_t   EPOCH_BIAS = 22'd719162;
	// 0001-01-01 is a Monday.
	localparam wd_t    WD_MONDAY  = 3'd1;
	localparam wd_t    WD_DAYS    = 3'd7;
	localparam cnt_t   CNT_CAP    = 5'd3;
	localparam cnt_t   CNT_CENT   = 5'd24;

	typedef enum logic [KIND_W-1:0] {
		K_SET        = 3'd0,
		K_EPOCH      = 3'd1,
		K_PREV_MONTH = 3'd2,
		K_NEXT_MONTH = 3'd3,
		K_PREV_DAY   = 3'd4,
		K_NEXT_DAY   = 3'd5,
		K_TOGGLE     = 3'd6,
		K_HOLD       = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD,
		OP_YACC,
		OP_DIV,
		OP_LEAP,
		OP_MONTH,
		OP_FINAL,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_ITEM,
		C_EPOCH,
		C_NOT_EPOCH,
		C_LOOP,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		LV_400 = 2'd0,
		LV_100 = 2'd1,
		LV_4   = 2'd2,
		LV_1   = 2'd3
	} level_t;

	typedef struct packed {
		op_t    op;
		level_t level;
		cond_t  cond;
		pc_t    jump;
		pc_t    next;
	} ucode_t;

	typedef struct packed {
		logic item;
		logic epoch;
		logic loop_ok;
		logic out_busy;
	} status_t;

	function automatic day_t month_len(input month_t m, input logic leap);
		day_t len;
		case (m)
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	// Weekday offset of the first of month m from January 1st.
	function automatic wd_t first_offset(input month_t m, input logic leap);
		wd_t base;
		case (m)
			4'd2, 4'd3, 4'd11: base = 3'd3;
			4'd4, 4'd7:        base = 3'd6;
			4'd5:              base = 3'd1;
			4'd6:              base = 3'd4;
			4'd8:              base = 3'd2;
			4'd9, 4'd12:       base = 3'd5;
			default:           base = 3'd0;
		endcase
		if (leap && (m > MONTH_FEB)) begin
			base = (base == (WD_DAYS - 3'd1)) ? 3'd0 : base + 3'd1;
		end
		return base;
	endfunction

	function automatic acc_t level_div(input level_t lv, input logic days);
		acc_t k;
		case (lv)
			LV_400:  k = days ? 22'd146097 : 22'd400;
			LV_100:  k = days ? 22'd36524  : 22'd100;
			LV_4:    k = days ? 22'd1461   : 22'd4;
			default: k = days ? 22'd365    : 22'd1;
		endcase
		return k;
	endfunction

	function automatic year_t level_inc(input level_t lv);
		year_t inc;
		case (lv)
			LV_400:  inc = 14'd400;
			LV_100:  inc = 14'd100;
			LV_4:    inc = 14'd4;
			default: inc = 14'd1;
		endcase
		return inc;
	endfunction

	// Days of one level's span, modulo 7.
	function automatic wd_t level_res(input level_t lv);
		wd_t r;
		case (lv)
			LV_400:  r = 3'd0;
			LV_100:  r = 3'd5;
			LV_4:    r = 3'd5;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic level_capped(input level_t lv);
		return (lv == LV_100) || (lv == LV_1);
	endfunction

	function automatic wd_t mod7(input logic [WD_W:0] s);
		logic [WD_W:0] r;
		r = (s >= {1'b0, WD_DAYS}) ? s - {1'b0, WD_DAYS} : s;
		return r[WD_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> src/cds_ifs.sv
`default_nettype none

interface cds_in_if import cds_pkg::*; ();
	logic   valid;
	logic   ready;
	logic [KIND_W-1:0] kind;
	year_t  set_year;
	month_t set_month;
	day_t   set_day;
	epoch_t epoch_days;

	modport source(output valid, kind, set_year, set_month, set_day, epoch_days, input ready);
	modport sink(input valid, kind, set_year, set_month, set_day, epoch_days, output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
	logic   valid;
	logic   ready;
	year_t  cur_year;
	month_t cur_month;
	day_t   cur_day;
	logic   highlight_on;
	day_t   month_length;
	wd_t    first_weekday;

	modport source(output valid, cur_year, cur_month, cur_day, highlight_on, month_length,
		first_weekday, input ready);
	modport sink(input valid, cur_year, cur_month, cur_day, highlight_on, month_length,
		first_weekday, output ready);
endinterface

`default_nettype wire

>>> src/cds_useq.sv
`default_nettype none

module cds_useq import cds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output ucode_t  uw,
	output logic    idle
);

	localparam pc_t ST_IDLE  = 4'd0;
	localparam pc_t ST_LOAD  = 4'd1;
	localparam pc_t ST_YACC  = 4'd2;
	localparam pc_t ST_L400  = 4'd3;
	localparam pc_t ST_L100  = 4'd4;
	localparam pc_t ST_L4    = 4'd5;
	localparam pc_t ST_L1    = 4'd6;
	localparam pc_t ST_LEAP  = 4'd7;
	localparam pc_t ST_MONTH = 4'd8;
	localparam pc_t ST_FINAL = 4'd9;
	localparam pc_t ST_EMIT  = 4'd10;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		unique case (pc)
			ST_IDLE:  w = '{OP_CAPTURE, LV_400, C_NO_ITEM,   ST_IDLE,  ST_LOAD};
			ST_LOAD:  w = '{OP_LOAD,    LV_400, C_EPOCH,     ST_L400,  ST_YACC};
			ST_YACC:  w = '{OP_YACC,    LV_400, C_NEVER,     ST_IDLE,  ST_L400};
			ST_L400:  w = '{OP_DIV,     LV_400, C_LOOP,      ST_L400,  ST_L100};
			ST_L100:  w = '{OP_DIV,     LV_100, C_LOOP,      ST_L100,  ST_L4};
			ST_L4:    w = '{OP_DIV,     LV_4,   C_LOOP,      ST_L4,    ST_L1};
			ST_L1:    w = '{OP_DIV,     LV_1,   C_LOOP,      ST_L1,    ST_LEAP};
			ST_LEAP:  w = '{OP_LEAP,    LV_400, C_NOT_EPOCH, ST_FINAL, ST_MONTH};
			ST_MONTH: w = '{OP_MONTH,   LV_400, C_LOOP,      ST_MONTH, ST_FINAL};
			ST_FINAL: w = '{OP_FINAL,   LV_400, C_NEVER,     ST_IDLE,  ST_EMIT};
			ST_EMIT:  w = '{OP_EMIT,    LV_400, C_OUT_BUSY,  ST_EMIT,  ST_IDLE};
			default:  w = '{OP_NONE,    LV_400, C_NEVER,     ST_IDLE,  ST_IDLE};
		endcase
		return w;
	endfunction

	pc_t  pc_q;
	pc_t  pc_d;
	logic take;

	assign uw   = ucode_rom(pc_q);
	assign idle = (pc_q == ST_IDLE);

	always_comb begin
		unique case (uw.cond)
			C_NO_ITEM:   take = !st.item;
			C_EPOCH:     take = st.epoch;
			C_NOT_EPOCH: take = !st.epoch;
			C_LOOP:      take = st.loop_ok;
			C_OUT_BUSY:  take = st.out_busy;
			default:     take = 1'b0;
		endcase
		pc_d = take ? uw.jump : uw.next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= ST_EMIT)
		else $error("step counter left the program");

	a_emit_leaves_on_free: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_EMIT) && !st.out_busy |=> pc_q == ST_IDLE)
		else $error("result step did not return to idle");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_IDLE) && !st.item |=> pc_q == ST_IDLE)
		else $error("sequencer started without an item");

endmodule

`default_nettype wire

>>> src/cds_dpath.sv
`default_nettype none

module cds_dpath import cds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  ucode_t uw,
	output status_t st,
	input  logic   item_valid,
	input  logic [KIND_W-1:0] kind,
	input  year_t  set_year,
	input  month_t set_month,
	input  day_t   set_day,
	input  epoch_t epoch_days,
	input  logic   out_ready,
	output logic   out_valid,
	output year_t  cur_year,
	output month_t cur_month,
	output day_t   cur_day,
	output logic   highlight_on,
	output day_t   month_length,
	output wd_t    first_weekday
);

	kind_t  kind_q;
	year_t  set_year_q;
	month_t set_month_q;
	day_t   set_day_q;
	epoch_t epoch_q;

	year_t  year_q;
	month_t month_q;
	day_t   day_q;
	logic   hl_q;
	logic   leap_q;
	wd_t    wd_q;

	acc_t   acc_q;
	cnt_t   cnt_q;
	logic [1:0] b_q;
	cnt_t   c_q;
	logic [1:0] e_q;

	logic   out_valid_q;

	logic   epoch;
	day_t   ml_cur;
	acc_t   div_k;
	logic   div_ok;
	logic   mon_ok;
	wd_t    wd_div;
	wd_t    wd_final;
	logic   leap_calc;
	logic   out_busy;
	logic   emit_load;
	epoch_t epoch_sat;

	assign epoch     = (kind_q == K_EPOCH);
	assign ml_cur    = month_len(month_q, leap_q);
	assign div_k     = level_div(uw.level, epoch);
	assign div_ok    = (acc_q >= div_k) && !(level_capped(uw.level) && (cnt_q == CNT_CAP));
	assign mon_ok    = (month_q < MONTH_DEC) && (acc_q >= ACC_W'(ml_cur));
	assign wd_div    = mod7({1'b0, wd_q} + {1'b0, level_res(uw.level)});
	assign wd_final  = mod7({1'b0, wd_q} + {1'b0, first_offset(month_q, leap_q)});
	// The fourth year of a four-year group is leap, except a century year not divisible by 400.
	assign leap_calc = (e_q == 2'd3) && ((c_q != CNT_CENT) || (b_q == 2'd3));
	assign epoch_sat = (epoch_q > EPOCH_MAX) ? EPOCH_MAX : epoch_q;
	assign out_busy  = out_valid_q && !out_ready;
	assign emit_load = (uw.op == OP_EMIT) && !out_busy;

	assign st.item     = item_valid;
	assign st.epoch    = epoch;
	assign st.loop_ok  = (uw.op == OP_MONTH) ? mon_ok : div_ok;
	assign st.out_busy = out_busy;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= EPOCH_YEAR;
			month_q <= MONTH_JAN;
			day_q   <= DAY_FIRST;
			hl_q    <= 1'b1;
			leap_q  <= 1'b0;
			wd_q    <= '0;
		end else begin
			unique case (uw.op)
				OP_LOAD: begin
					wd_q <= WD_MONDAY;
					unique case (kind_q)
						K_SET: begin
							if (set_year_q < YEAR_MIN) begin
								year_q <= YEAR_MIN;
							end else if (set_year_q > YEAR_MAX) begin
								year_q <= YEAR_MAX;
							end else begin
								year_q <= set_year_q;
							end
							if (set_month_q < MONTH_JAN) begin
								month_q <= MONTH_JAN;
							end else if (set_month_q > MONTH_DEC) begin
								month_q <= MONTH_DEC;
							end else begin
								month_q <= set_month_q;
							end
							// The upper bound on the day is applied once the year is known.
							day_q <= (set_day_q < DAY_FIRST) ? DAY_FIRST : set_day_q;
							hl_q  <= 1'b1;
						end
						K_EPOCH: begin
							year_q  <= YEAR_MIN;
							month_q <= MONTH_JAN;
						end
						K_PREV_MONTH: begin
							if (month_q == MONTH_JAN) begin
								if (year_q > YEAR_MIN) begin
									year_q  <= year_q - YEAR_MIN;
									month_q <= MONTH_DEC;
								end
							end else begin
								month_q <= month_q - MONTH_JAN;
							end
						end
						K_NEXT_MONTH: begin
							if (month_q == MONTH_DEC) begin
								if (year_q < YEAR_MAX) begin
									year_q  <= year_q + YEAR_MIN;
									month_q <= MONTH_JAN;
								end
							end else begin
								month_q <= month_q + MONTH_JAN;
							end
						end
						K_PREV_DAY: begin
							// A day of 31 is cut to the month's length in the final step.
							if (day_q > DAY_FIRST) begin
								day_q <= day_q - DAY_FIRST;
							end else if (month_q > MONTH_JAN) begin
								month_q <= month_q - MONTH_JAN;
								day_q   <= DAY_LAST;
							end else if (year_q > YEAR_MIN) begin
								year_q  <= year_q - YEAR_MIN;
								month_q <= MONTH_DEC;
								day_q   <= DAY_LAST;
							end
						end
						K_NEXT_DAY: begin
							if (day_q < ml_cur) begin
								day_q <= day_q + DAY_FIRST;
							end else if (month_q < MONTH_DEC) begin
								month_q <= month_q + MONTH_JAN;
								day_q   <= DAY_FIRST;
							end else if (year_q < YEAR_MAX) begin
								year_q  <= year_q + YEAR_MIN;
								month_q <= MONTH_JAN;
								day_q   <= DAY_FIRST;
							end
						end
						K_TOGGLE: hl_q <= ~hl_q;
						default: ;
					endcase
				end
				OP_DIV: begin
					if (div_ok) begin
						wd_q <= wd_div;
						if (epoch) begin
							year_q <= year_q + level_inc(uw.level);
						end
					end
				end
				OP_LEAP: leap_q <= leap_calc;
				OP_MONTH: begin
					if (mon_ok) begin
						month_q <= month_q + MONTH_JAN;
					end else begin
						day_q <= acc_q[DAY_W-1:0] + DAY_FIRST;
					end
				end
				OP_FINAL: begin
					if (day_q > ml_cur) begin
						day_q <= ml_cur;
					end
					wd_q <= wd_final;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_CAPTURE: begin
				if (item_valid) begin
					kind_q      <= kind_t'(kind);
					set_year_q  <= set_year;
					set_month_q <= set_month;
					set_day_q   <= set_day;
					epoch_q     <= epoch_days;
				end
			end
			OP_LOAD: begin
				cnt_q <= '0;
				if (epoch) begin
					acc_q <= ACC_W'(epoch_sat) + EPOCH_BIAS;
				end
			end
			OP_YACC: acc_q <= ACC_W'(year_q) - ACC_W'(YEAR_MIN);
			OP_DIV: begin
				if (div_ok) begin
					acc_q <= acc_q - div_k;
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					case (uw.level)
						LV_100:  b_q <= cnt_q[1:0];
						LV_4:    c_q <= cnt_q;
						LV_1:    e_q <= cnt_q[1:0];
						default: ;
					endcase
					cnt_q <= '0;
				end
			end
			OP_MONTH: begin
				if (mon_ok) begin
					acc_q <= acc_q - ACC_W'(ml_cur);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			cur_year      <= year_q;
			cur_month     <= month_q;
			cur_day       <= day_q;
			highlight_on  <= hl_q;
			month_length  <= ml_cur;
			first_weekday <= wd_q;
		end
	end

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= MONTH_JAN) && (month_q <= MONTH_DEC))
		else $error("month register out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(year_q >= YEAR_MIN) && (year_q <= YEAR_MAX))
		else $error("year register out of range");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		wd_q < WD_DAYS)
		else $error("weekday accumulator not reduced");

	a_result_day: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cur_day >= DAY_FIRST) && (cur_day <= month_length))
		else $error("reported day lies outside its month");

endmodule

`default_nettype wire

>>> src/calendar_date_stepper_unit.sv
// The time to a result is set by the repeated-subtraction loops of the shared divide step
// (400, 100, 4 and 1 year levels), plus the month steps of a day-count conversion.
// Items are taken one at a time; the next item is accepted once the result sits in the
// output register, so a held result stalls the sequencer only at its final step.
// Reset (arst_n low) sets the date to 1970-01-01 with highlight on and empties the output.
`default_nettype none

module calendar_date_stepper_unit import cds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cds_in_if.sink    item,
	cds_out_if.source result
);

	ucode_t  uw;
	status_t st;
	logic    idle;

	assign item.ready = idle;

	cds_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.uw     (uw),
		.idle   (idle)
	);

	cds_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.uw            (uw),
		.st            (st),
		.item_valid    (item.valid),
		.kind          (item.kind),
		.set_year      (item.set_year),
		.set_month     (item.set_month),
		.set_day       (item.set_day),
		.epoch_days    (item.epoch_days),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.cur_year      (result.cur_year),
		.cur_month     (result.cur_month),
		.cur_day       (result.cur_day),
		.highlight_on  (result.highlight_on),
		.month_length  (result.month_length),
		.first_weekday (result.first_weekday)
	);

endmodule

`default_nettype wire

>>> tb/calendar_date_stepper_unit_tb.sv
module calendar_date_stepper_unit_tb;
	import cds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES   = 120;
	localparam int unsigned HOLD_OFF       = 400;

	typedef struct {
		year_t  year;
		month_t month;
		day_t   day;
		logic   highlight;
		day_t   month_len;
		wd_t    first_wd;
	} date_report_t;

	logic clk;
	logic arst_n;

	cds_in_if  in_if();
	cds_out_if out_if();

	calendar_date_stepper_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_if.sink),
		.result (out_if.source)
	);

	// Calendar state as the block should hold it.
	year_t  cal_year;
	month_t cal_month;
	day_t   cal_day;
	logic   cal_highlight;

	date_report_t pending_reports[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_cycles;
	int unsigned quiet_cycles;
	int unsigned error_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
		int unsigned n;
		case (m)
			2:             n = is_leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   n = 30;
			default:       n = 31;
		endcase
		return n;
	endfunction

	// Counts days from 0001-01-01, which fell on a Monday.
	function automatic int unsigned weekday_of_first(input int unsigned y, input int unsigned m);
		int unsigned p;
		int unsigned n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (int unsigned i = 1; i < m; i++) begin
			n += days_in(y, i);
		end
		return (n + 1) % 7;
	endfunction

	function automatic date_report_t advance_calendar(input kind_t k, input year_t sy,
		input month_t sm, input day_t sd, input epoch_t ed);
		int unsigned y;
		int unsigned m;
		int unsigned d;
		int unsigned cnt;
		date_report_t r;
		y = cal_year;
		m = cal_month;
		d = cal_day;
		case (k)
			K_SET: begin
				y = sy;
				m = sm;
				d = sd;
				if (y < YEAR_MIN) y = YEAR_MIN;
				if (y > YEAR_MAX) y = YEAR_MAX;
				if (m < 1) m = 1;
				if (m > 12) m = 12;
				if (d < 1) d = 1;
				if (d > days_in(y, m)) d = days_in(y, m);
				cal_highlight = 1'b1;
			end
			K_EPOCH: begin
				cnt = ed;
				if (cnt > EPOCH_MAX) cnt = EPOCH_MAX;
				y = EPOCH_YEAR;
				m = 1;
				while (y < YEAR_MAX && cnt >= (is_leap_year(y) ? 366 : 365)) begin
					cnt -= is_leap_year(y) ? 366 : 365;
					y++;
				end
				while (m < 12 && cnt >= days_in(y, m)) begin
					cnt -= days_in(y, m);
					m++;
				end
				d = cnt + 1;
			end
			K_PREV_MONTH: begin
				if (m > 1) begin
					m--;
				end else if (y > YEAR_MIN) begin
					y--;
					m = 12;
				end
				if (d > days_in(y, m)) d = days_in(y, m);
			end
			K_NEXT_MONTH: begin
				if (m < 12) begin
					m++;
				end else if (y < YEAR_MAX) begin
					y++;
					m = 1;
				end
				if (d > days_in(y, m)) d = days_in(y, m);
			end
			K_PREV_DAY: begin
				if (d > 1) begin
					d--;
				end else if (m > 1) begin
					m--;
					d = days_in(y, m);
				end else if (y > YEAR_MIN) begin
					y--;
					m = 12;
					d = 31;
				end
			end
			K_NEXT_DAY: begin
				if (d < days_in(y, m)) begin
					d++;
				end else if (m < 12) begin
					m++;
					d = 1;
				end else if (y < YEAR_MAX) begin
					y++;
					m = 1;
					d = 1;
				end
			end
			K_TOGGLE: cal_highlight = ~cal_highlight;
			default: ;
		endcase
		cal_year  = year_t'(y);
		cal_month = month_t'(m);
		cal_day   = day_t'(d);
		r.year      = cal_year;
		r.month     = cal_month;
		r.day       = cal_day;
		r.highlight = cal_highlight;
		r.month_len = day_t'(days_in(y, m));
		r.first_wd  = wd_t'(weekday_of_first(y, m));
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		error_count++;
	endtask

	// The valid line is only lowered when an idle gap is taken, so back-to-back beats
	// keep it high without a second assignment in the same step.
	task automatic send_item(input kind_t k, input year_t sy, input month_t sm,
		input day_t sd, input epoch_t ed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid      <= 1'b1;
		in_if.kind       <= k;
		in_if.set_year   <= sy;
		in_if.set_month  <= sm;
		in_if.set_day    <= sd;
		in_if.epoch_days <= ed;
		do @(posedge clk); while (!in_if.ready);
		pending_reports.push_back(advance_calendar(k, sy, sm, sd, ed));
	endtask

	// Steps carry random junk in the unused fields.
	task automatic send_op(input kind_t k);
		send_item(k, year_t'($urandom), month_t'($urandom), day_t'($urandom),
			epoch_t'($urandom));
	endtask

	task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
		send_item(K_SET, year_t'(y), month_t'(m), day_t'(d), epoch_t'($urandom));
	endtask

	task automatic send_epoch(input int unsigned days);
		send_item(K_EPOCH, year_t'($urandom), month_t'($urandom), day_t'($urandom),
			epoch_t'(days));
	endtask

	task automatic send_random_item();
		int unsigned pick;
		kind_t  k;
		year_t  y;
		month_t m;
		day_t   d;
		epoch_t e;
		pick = $urandom_range(99);
		y = year_t'($urandom);
		m = month_t'($urandom);
		d = day_t'($urandom);
		e = epoch_t'($urandom);
		if (pick < 14) begin
			k = K_SET;
			if ($urandom_range(9) < 7) begin
				case ($urandom_range(6))
					0:       y = year_t'($urandom_range(3, 1));
					1:       y = year_t'($urandom_range(9999, 9997));
					default: y = year_t'($urandom_range(9999, 1));
				endcase
				m = month_t'($urandom_range(12, 1));
				d = day_t'($urandom_range(31, 1));
			end
		end else if (pick < 24) begin
			k = K_EPOCH;
			case ($urandom_range(9))
				0:       ;
				1:       e = epoch_t'(EPOCH_MAX - $urandom_range(800));
				2:       e = epoch_t'($urandom_range(800));
				default: e = epoch_t'($urandom_range(EPOCH_MAX));
			endcase
		end else if (pick < 40) begin
			k = K_PREV_MONTH;
		end else if (pick < 56) begin
			k = K_NEXT_MONTH;
		end else if (pick < 76) begin
			k = K_PREV_DAY;
		end else if (pick < 96) begin
			k = K_NEXT_DAY;
		end else if (pick < 99) begin
			k = K_TOGGLE;
		end else begin
			k = K_HOLD;
		end
		send_item(k, y, m, d, e);
	endtask

	task automatic test_reset_state();
		send_op(K_HOLD);
		send_op(K_TOGGLE);
		send_op(K_TOGGLE);
	endtask

	task automatic test_set_date_clamps();
		send_date(0, 0, 0);
		send_date(16383, 15, 31);
		send_date(2000, 2, 31);
		send_date(1900, 2, 30);
		send_date(2024, 4, 31);
	endtask

	// The highlight is switched off first so that conversions show it is left alone.
	task automatic test_epoch_conversion();
		send_op(K_TOGGLE);
		send_epoch(0);
		send_epoch(364);
		send_epoch(365);
		send_epoch(1095);
		send_epoch(EPOCH_MAX);
		send_epoch(22'h3FFFFF);
	endtask

	task automatic test_month_steps();
		send_date(1, 1, 15);
		send_op(K_PREV_MONTH);
		send_date(9999, 12, 31);
		send_op(K_NEXT_MONTH);
		send_date(2023, 1, 31);
		send_op(K_NEXT_MONTH);
		send_date(2024, 3, 31);
		send_op(K_PREV_MONTH);
	endtask

	task automatic test_day_steps();
		send_date(1, 1, 1);
		send_op(K_PREV_DAY);
		send_op(K_NEXT_DAY);
		send_date(9999, 12, 31);
		send_op(K_NEXT_DAY);
		send_date(2024, 2, 29);
		send_op(K_NEXT_DAY);
		send_op(K_PREV_DAY);
		send_date(2023, 12, 31);
		send_op(K_NEXT_DAY);
		send_op(K_PREV_DAY);
	endtask

	task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
		input int unsigned stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_item();
	endtask

	// The receiver holds off long enough for the block to fill and refuse new beats.
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_cycles    = HOLD_OFF;
		repeat (12) send_random_item();
	endtask

	// Result checking, receiver ready and the idle counter share one edge process.
	always @(posedge clk) begin
		date_report_t want;
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("result beat with nothing pending", out_if.cur_year, 0);
			end else begin
				want = pending_reports.pop_front();
				if (out_if.cur_year !== want.year)
					report_mismatch("cur_year", out_if.cur_year, want.year);
				if (out_if.cur_month !== want.month)
					report_mismatch("cur_month", out_if.cur_month, want.month);
				if (out_if.cur_day !== want.day)
					report_mismatch("cur_day", out_if.cur_day, want.day);
				if (out_if.highlight_on !== want.highlight)
					report_mismatch("highlight_on", out_if.highlight_on, want.highlight);
				if (out_if.month_length !== want.month_len)
					report_mismatch("month_length", out_if.month_length, want.month_len);
				if (out_if.first_weekday !== want.first_wd)
					report_mismatch("first_weekday", out_if.first_weekday, want.first_wd);
			end
		end
		if (hold_cycles > 0) begin
			out_if.ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("calendar_date_stepper_unit verification failed");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		in_if.valid      = 1'b0;
		in_if.kind       = K_HOLD;
		in_if.set_year   = '0;
		in_if.set_month  = '0;
		in_if.set_day    = '0;
		in_if.epoch_days = '0;
		out_if.ready     = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_cycles      = 0;
		quiet_cycles     = 0;
		error_count      = 0;
		cal_year         = EPOCH_YEAR;
		cal_month        = MONTH_JAN;
		cal_day          = DAY_FIRST;
		cal_highlight    = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_set_date_clamps();
		test_epoch_conversion();
		test_month_steps();
		test_day_steps();
		test_random_traffic(400, 0, 0);
		test_random_traffic(400, 88, 0);
		test_random_traffic(400, 0, 88);
		test_random_traffic(400, 35, 35);
		test_output_backpressure();
		test_random_traffic(60, 0, 0);

		in_if.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("calendar_date_stepper_unit verification clean");
		end else begin
			$display("calendar_date_stepper_unit verification failed");
		end
		$finish;
	end

endmodule
